// ===== hdl/dsf_pkg.sv =====
// Package for the duplicate read site filter.
// Holds table geometry, the entry and result types and the operation codes.
// No dependencies.
package dsf_pkg;

    localparam int POSITIONS  = 1048576;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_BITS  = $clog2(POSITIONS);

    localparam int POS_BITS   = 20;
    localparam int QUAL_BITS  = 8;
    localparam int THR_BITS   = 16;
    localparam int DEPTH_BITS = 16;
    localparam int OP_BITS    = 2;

    localparam int S_TDATA_BITS = 32;
    localparam int M_TDATA_BITS = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
    localparam logic [THR_BITS-1:0]   THR_RESET    = THR_BITS'(2);
    localparam logic [THR_BITS-1:0]   THR_BEST_ONE = THR_BITS'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_COUNT  = 2'd1,
        OP_SCAN   = 2'd2,
        OP_FILTER = 2'd3
    } t_op;

    typedef struct packed {
        logic                  taken;
        logic [QUAL_BITS-1:0]  best;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic                  dup;
        logic [DEPTH_BITS-1:0] depth;
        logic                  keep;
    } t_result;

    localparam int ENTRY_BITS  = $bits(t_entry);
    localparam int RESULT_BITS = $bits(t_result);

endpackage

// ===== hdl/dsf_table_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; used for the per-position table. No package dependency.
module dsf_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dsf_update.sv =====
// Entry update logic: computes the new table entry and the result for one request.
// Depends on dsf_pkg.
module dsf_update
    import dsf_pkg::*;
(
    input  t_op                  i_op,
    input  logic [QUAL_BITS-1:0] i_quality,
    input  t_entry               i_entry,
    input  logic [THR_BITS-1:0]  i_threshold,
    input  logic                 i_in_range,
    output t_entry               o_entry,
    output logic                 o_write,
    output t_result              o_result
);

    logic        keep;
    logic [31:0] count_wide;

    always_comb begin
        o_entry = i_entry;
        o_write = 1'b0;
        keep    = 1'b0;
        unique case (i_op)
            OP_CLEAR: begin
                o_entry = '0;
                o_write = 1'b1;
            end
            OP_COUNT: begin
                if (i_entry.count != COUNT_MAX) begin
                    o_entry.count = i_entry.count + COUNT_BITS'(1);
                end
                if (i_quality > i_entry.best) begin
                    o_entry.best = i_quality;
                end
                o_write = 1'b1;
            end
            OP_SCAN: begin
                o_write = 1'b0;
            end
            OP_FILTER: begin
                if (i_threshold != THR_BEST_ONE) begin
                    keep = (32'(i_entry.count) < 32'(i_threshold));
                end else if (i_quality == i_entry.best && !i_entry.taken) begin
                    keep          = 1'b1;
                    o_entry.taken = 1'b1;
                    o_write       = 1'b1;
                end
            end
            default: begin
                o_write = 1'b0;
            end
        endcase

        count_wide = 32'(o_entry.count);
        if (i_in_range) begin
            o_result.keep  = keep;
            o_result.depth = (count_wide > 32'hFFFF) ? DEPTH_BITS'(16'hFFFF)
                                                     : count_wide[DEPTH_BITS-1:0];
            o_result.dup   = (count_wide >= 32'(i_threshold));
        end else begin
            o_result = '0;
        end
    end

endmodule

// ===== hdl/duplicate_read_site_filter.sv =====
// Duplicate read site filter: per-position count, best quality and taken mark table.
// Each request reads its entry from the table into the RAM's registered read data, then
// the update is written back and the result goes into the output register; both wait
// while that register is still held. Only one request is in the table read-modify-write
// at a time. Reset: a clearing pass zeroes all POSITIONS (1,048,576) entries with
// s_axis_tready low; configuration writes are taken throughout.
module duplicate_read_site_filter
    import dsf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // position[19:0], map_quality[27:20]
    input  logic [OP_BITS-1:0]      s_axis_tuser,  // op[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,  // keep_read[0], site_depth[16:1],
                                                   // duplicate_site[17]
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [THR_BITS-1:0]     i_cfg_data     // dup_threshold[15:0]
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state                r_state;
    logic [ADDR_BITS-1:0]  r_sweep_addr;
    t_op                   r_op;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [QUAL_BITS-1:0]  r_quality;
    logic                  r_in_range;
    logic                  r_out_valid;
    t_result               r_out;
    logic [THR_BITS-1:0]   r_threshold;

    logic                  in_accept;
    logic                  out_free;
    logic [POS_BITS-1:0]   in_position;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    t_entry                ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    t_entry                upd_entry;
    logic                  upd_write;
    t_result               upd_result;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_position   = s_axis_tdata[POS_BITS-1:0];
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_BITS'(r_out);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = upd_entry;
        if (r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end else if (r_state == ST_EXEC && out_free) begin
            ram_we = upd_write && r_in_range;
        end
    end

    dsf_table_ram #(
        .DEPTH (POSITIONS),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (ADDR_BITS'(in_position)),
        .o_rdata (ram_rdata)
    );

    dsf_update u_update (
        .i_op        (r_op),
        .i_quality   (r_quality),
        .i_entry     (t_entry'(ram_rdata)),
        .i_threshold (r_threshold),
        .i_in_range  (r_in_range),
        .o_entry     (upd_entry),
        .o_write     (upd_write),
        .o_result    (upd_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
            r_threshold  <= THR_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end
            if (r_state == ST_EXEC && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + ADDR_BITS'(1);
                    if (32'(r_sweep_addr) == POSITIONS - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_out   <= upd_result;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= t_op'(s_axis_tuser);
            r_addr     <= ADDR_BITS'(in_position);
            r_quality  <= s_axis_tdata[POS_BITS +: QUAL_BITS];
            r_in_range <= (32'(in_position) < 32'(POSITIONS));
        end
    end

endmodule

// ===== hdl/dsf_checker.sv =====
// Port-level checker for the duplicate read site filter, bound to the top level.
// Depends on dsf_pkg.
module dsf_checker
    import dsf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request accepted or result offered right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in the table update");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_BITS-1:RESULT_BITS] == '0)
        else $error("result padding bits not zero");

endmodule

bind duplicate_read_site_filter dsf_checker u_dsf_checker (.*);

// ===== test/testbench.sv =====
// Testbench for duplicate_read_site_filter: directed and random requests checked
// against a behavioral model of the per-position count, best quality and taken mark table.
// Depends on dsf_pkg and the duplicate_read_site_filter RTL.
module testbench
    import dsf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The limit covers the clearing pass over all POSITIONS entries and the random part, about
    // 1,650 requests, each with at worst its longest idle gap, its table work and its longest
    // output stall, taken with a wide margin.
    localparam int CYCLE_LIMIT  = 4 * POSITIONS;
    localparam int PHASE_ITEMS  = 275;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 10;
    localparam int COUNT_RUN    = 20;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    logic [OP_BITS-1:0]      s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [THR_BITS-1:0]     i_cfg_data;

    bit [COUNT_BITS-1:0] site_count [int];
    bit [QUAL_BITS-1:0]  site_best [int];
    bit                  site_taken [int];
    logic [THR_BITS-1:0] threshold_now;

    t_result            pending_results [$];
    logic [POS_BITS-1:0] site_pool [POOL_SIZE];

    bit idle_on;
    int stall_left;
    int cycle_count;
    int error_count;
    int requests_sent;
    int results_checked;

    duplicate_read_site_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_result predict_site_result(t_op op, logic [POS_BITS-1:0] pos,
                                                    logic [QUAL_BITS-1:0] qual);
        t_result     res;
        int          idx;
        longint      cnt;
        idx = int'(pos);
        res = '0;
        if (!site_count.exists(idx)) begin
            site_count[idx] = '0;
            site_best[idx]  = '0;
            site_taken[idx] = 1'b0;
        end
        case (op)
            OP_CLEAR: begin
                site_count[idx] = '0;
                site_best[idx]  = '0;
                site_taken[idx] = 1'b0;
            end
            OP_COUNT: begin
                if (site_count[idx] != COUNT_MAX)
                    site_count[idx] = site_count[idx] + 1'b1;
                if (qual > site_best[idx])
                    site_best[idx] = qual;
            end
            OP_FILTER: begin
                if (threshold_now != THR_BEST_ONE) begin
                    res.keep = (longint'(site_count[idx]) < longint'(threshold_now));
                end else if (qual == site_best[idx] && !site_taken[idx]) begin
                    res.keep        = 1'b1;
                    site_taken[idx] = 1'b1;
                end
            end
            default: ;
        endcase
        cnt       = longint'(site_count[idx]);
        res.depth = (cnt > 64'hFFFF) ? '1 : DEPTH_BITS'(cnt);
        res.dup   = (cnt >= longint'(threshold_now));
        return res;
    endfunction

    // Returns right after acceptance with tvalid still high, so that back-to-back
    // requests stay back to back; any caller that stops sending lowers tvalid at once.
    task automatic send_request(t_op op, logic [POS_BITS-1:0] pos, logic [QUAL_BITS-1:0] qual);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_BITS'({qual, pos});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_site_result(op, pos, qual));
        requests_sent++;
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        threshold_now = value;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RESULT_BITS-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.keep !== want.keep) begin
                    $display("%0t: keep_read expected %0d actual %0d", $time, want.keep,
                             got.keep);
                    error_count++;
                end
                if (got.depth !== want.depth) begin
                    $display("%0t: site_depth expected %0d actual %0d", $time, want.depth,
                             got.depth);
                    error_count++;
                end
                if (got.dup !== want.dup) begin
                    $display("%0t: duplicate_site expected %0d actual %0d", $time, want.dup,
                             got.dup);
                    error_count++;
                end
            end
        end
    end

    task automatic test_threshold_mode;
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_COUNT, '0, 8'hFF);
        send_request(OP_FILTER, '0, '0);
        send_request(OP_COUNT, '0, '0);
        send_request(OP_FILTER, '0, 8'hFF);
        send_request(OP_SCAN, '0, '0);
        send_request(OP_COUNT, '1, 8'hFF);
        send_request(OP_SCAN, '1, 8'hFF);
    endtask

    task automatic test_threshold_zero;
        write_threshold('0);
        send_request(OP_FILTER, 20'h12345, 8'h5A);
        send_request(OP_SCAN, 20'hEDCBA, 8'hA5);
    endtask

    task automatic test_best_quality_mode;
        write_threshold(THR_BEST_ONE);
        send_request(OP_CLEAR, 20'h00A5A, '0);
        send_request(OP_COUNT, 20'h00A5A, 8'd30);
        send_request(OP_COUNT, 20'h00A5A, 8'd60);
        send_request(OP_FILTER, 20'h00A5A, 8'd40);
        send_request(OP_FILTER, 20'h00A5A, 8'd60);
        send_request(OP_FILTER, 20'h00A5A, 8'd60);
        send_request(OP_COUNT, 20'h00A5A, 8'd70);
        send_request(OP_FILTER, 20'h00A5A, 8'd70);
        send_request(OP_CLEAR, 20'h00A5A, '0);
        send_request(OP_FILTER, 20'h00A5A, '0);
    endtask

    task automatic test_threshold_max;
        write_threshold('1);
        send_request(OP_SCAN, '0, '0);
        send_request(OP_FILTER, '0, '0);
    endtask

    task automatic test_count_run;
        send_request(OP_CLEAR, 20'h55555, '0);
        repeat (COUNT_RUN) send_request(OP_COUNT, 20'h55555, 8'h33);
        send_request(OP_SCAN, 20'h55555, '0);
        send_request(OP_FILTER, 20'h55555, '0);
    endtask

    task automatic test_random_traffic;
        logic [THR_BITS-1:0]  phase_thr [6];
        logic [POS_BITS-1:0]  pos;
        logic [QUAL_BITS-1:0] qual;
        t_op                  op;
        int                   pick;
        phase_thr[0] = THR_RESET;
        phase_thr[1] = THR_BEST_ONE;
        phase_thr[2] = '0;
        phase_thr[3] = THR_BITS'($urandom_range(3, 10));
        phase_thr[4] = THR_BITS'($urandom_range(0, 16'hFFFF));
        phase_thr[5] = THR_BEST_ONE;
        site_pool[0] = '0;
        site_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            site_pool[i] = POS_BITS'($urandom_range(0, 20'hFFFFF));
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(phase_thr[ph]);
            if (ph == 5)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    op = OP_CLEAR;
                else if (pick < 50)
                    op = OP_COUNT;
                else if (pick < 65)
                    op = OP_SCAN;
                else
                    op = OP_FILTER;
                if ($urandom_range(0, 3) != 0)
                    pos = site_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    pos = POS_BITS'($urandom_range(0, 20'hFFFFF));
                if ($urandom_range(0, 3) == 0)
                    qual = QUAL_BITS'($urandom_range(0, 255));
                else
                    qual = QUAL_BITS'($urandom_range(0, 5));
                send_request(op, pos, qual);
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_CLEAR;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        threshold_now = THR_RESET;
        idle_on       = 1'b1;
        stall_left    = 0;
        cycle_count   = 0;
        error_count   = 0;
        requests_sent = 0;
        results_checked = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_threshold_mode();
        test_threshold_zero();
        test_best_quality_mode();
        test_threshold_max();
        test_count_run();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results: all four operations, a run",
                 requests_sent, results_checked);
        $display("of counts on one site, and thresholds 0, 1 (best quality), 2, 65535 and random.");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dsf_pkg.sv
hdl/dsf_table_ram.sv
hdl/dsf_update.sv
hdl/duplicate_read_site_filter.sv
hdl/dsf_checker.sv
test/testbench.sv
